// ===== hw/rtl/sro_pkg.sv =====
package sro_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int SEQ_W     = 32;
	localparam int TAG_W     = 16;
	localparam int CNT_W     = 5;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_PURGE  = 1'b1
	} sro_func_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_PURGED    = 2'd3
	} sro_status_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_PURGE
	} sro_state_t;

	typedef struct packed {
		sro_func_t          func;
		logic [SEQ_W-1:0]   seq_number;
		logic [TAG_W-1:0]   payload_tag;
	} sro_req_t;

	typedef struct packed {
		sro_status_t        status;
		logic [CNT_W-1:0]   occupancy;
		logic [CNT_W-1:0]   purged_count;
	} sro_rsp_t;

	typedef struct packed {
		logic               valid;
		logic [SEQ_W-1:0]   seq;
		logic [TAG_W-1:0]   tag;
	} sro_entry_t;

	typedef struct packed {
		logic               ins;
		logic               pull;
		logic [SEQ_W-1:0]   seq;
		logic [TAG_W-1:0]   tag;
	} sro_cmd_t;

endpackage

// ===== hw/rtl/sro_cell.sv =====
module sro_cell
	import sro_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  sro_cmd_t   cmd,
	input  logic       left_flag,
	input  sro_entry_t left_ent,
	input  sro_entry_t right_ent,
	output sro_entry_t ent,
	output logic       flag,
	output logic       eq
);

	logic             valid_q;
	logic [SEQ_W-1:0] seq_q;
	logic [TAG_W-1:0] tag_q;
	sro_entry_t       nxt;
	logic             load;

	assign ent  = '{valid: valid_q, seq: seq_q, tag: tag_q};
	assign flag = !valid_q || (seq_q > cmd.seq);
	assign eq   = valid_q && (seq_q == cmd.seq);

	always_comb begin
		nxt  = ent;
		load = 1'b0;
		if (cmd.ins) begin
			if (left_flag) begin
				nxt  = left_ent;
				load = 1'b1;
			end else if (flag) begin
				nxt  = '{valid: 1'b1, seq: cmd.seq, tag: cmd.tag};
				load = 1'b1;
			end
		end else if (cmd.pull) begin
			nxt  = right_ent;
			load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seq_q <= nxt.seq;
			tag_q <= nxt.tag;
		end
	end

endmodule

// ===== hw/rtl/sorted_reorder_buffer_unit.sv =====
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | sro_req_t (func, seq_number, payload_tag)
// rsp     | out       | rsp_valid, rsp_stall | sro_rsp_t (status, occupancy, purged_count)
//
// An insert is done and its result registered when the request is taken; a purge
// pulls one entry per cycle from the head cell, then loads its result when rsp is free.
// One item is in flight at a time; the result sits in an output register.
// Reset empties the chain at once (valid bits only); no clearing pass.
// A result held by rsp_stall blocks the next transfer on req.
module sorted_reorder_buffer_unit
	import sro_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  sro_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output sro_rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	sro_entry_t       ent   [DEPTH];
	logic [DEPTH-1:0] flags;
	logic [DEPTH-1:0] eqs;
	sro_cmd_t         cmd;

	sro_state_t       state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    pcnt_q, pcnt_d;
	logic [SEQ_W-1:0] thr_q;
	logic             rsp_valid_q;
	sro_rsp_t         rsp_q, rsp_d;
	logic             rsp_load;
	logic             out_free;
	logic             acc;
	logic             dup;
	logic             full;
	logic             head_lt;
	logic [31:0]      occ_w;
	logic [31:0]      pc_w;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sro_entry_t l_ent, r_ent;
		logic       l_flag;
		if (i == 0) begin : g_first
			assign l_ent  = '0;
			assign l_flag = 1'b0;
		end else begin : g_mid
			assign l_ent  = ent[i-1];
			assign l_flag = flags[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign r_ent = '0;
		end else begin : g_next
			assign r_ent = ent[i+1];
		end
		sro_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_flag (l_flag),
			.left_ent  (l_ent),
			.right_ent (r_ent),
			.ent       (ent[i]),
			.flag      (flags[i]),
			.eq        (eqs[i])
		);
	end

	assign dup     = |eqs;
	assign full    = ent[DEPTH-1].valid;
	assign head_lt = ent[0].valid && (ent[0].seq < thr_q);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != CTL_IDLE) || !out_free;
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		pcnt_d   = pcnt_q;
		rsp_d    = rsp_q;
		rsp_load = 1'b0;
		cmd      = '{ins: 1'b0, pull: 1'b0, seq: req.seq_number, tag: req.payload_tag};
		occ_w    = 32'(count_q);
		pc_w     = 32'(pcnt_q);
		unique case (state_q)
			CTL_IDLE: begin
				if (acc) begin
					if (req.func == FUNC_INSERT) begin
						rsp_load = 1'b1;
						if (dup) begin
							rsp_d.status = ST_DUPLICATE;
						end else if (full) begin
							rsp_d.status = ST_FULL;
						end else begin
							rsp_d.status = ST_INSERTED;
							cmd.ins      = 1'b1;
							count_d      = count_q + CW'(1);
							occ_w        = 32'(count_d);
						end
						rsp_d.occupancy    = occ_w[CNT_W-1:0];
						rsp_d.purged_count = '0;
					end else begin
						pcnt_d  = '0;
						state_d = CTL_PURGE;
					end
				end
			end
			CTL_PURGE: begin
				if (head_lt) begin
					cmd.pull = 1'b1;
					count_d  = count_q - CW'(1);
					pcnt_d   = pcnt_q + CW'(1);
				end else if (out_free) begin
					rsp_load           = 1'b1;
					rsp_d.status       = ST_PURGED;
					rsp_d.occupancy    = occ_w[CNT_W-1:0];
					rsp_d.purged_count = pc_w[CNT_W-1:0];
					state_d            = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			count_q     <= '0;
			pcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pcnt_q  <= pcnt_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (acc) begin
			thr_q <= req.seq_number;
		end
	end

endmodule

// ===== bench/tb_sorted_reorder_buffer_unit.sv =====
`timescale 1ns / 100ps

module tb_sorted_reorder_buffer_unit;
	import sro_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned MAX_WAIT    = 18;
	localparam int unsigned PHASES      = 10;
	localparam int unsigned PHASE_ITEMS = 135;

	class reorder_shadow;
		logic [SEQ_W-1:0] held_seq [DEPTH_DEF];
		logic [TAG_W-1:0] held_tag [DEPTH_DEF];
		int unsigned      held_count;
		sro_rsp_t         awaited_rsp [$];
		int unsigned      errors;

		function new();
			held_count = 0;
			errors     = 0;
		endfunction

		function int unsigned pending();
			return awaited_rsp.size();
		endfunction

		function void note_request(input sro_req_t r);
			sro_rsp_t    e;
			int unsigned pos;
			int unsigned n;
			int unsigned i;
			bit          dup;

			e.purged_count = '0;
			if (r.func == FUNC_INSERT) begin
				dup = 1'b0;
				for (i = 0; i < held_count; i++)
					if (held_seq[i] == r.seq_number)
						dup = 1'b1;
				if (dup) begin
					e.status = ST_DUPLICATE;
				end else if (held_count >= DEPTH_DEF) begin
					e.status = ST_FULL;
				end else begin
					pos = held_count;
					for (i = 0; i < held_count; i++)
						if (held_seq[i] > r.seq_number && pos == held_count)
							pos = i;
					for (i = held_count; i > pos; i--) begin
						held_seq[i] = held_seq[i-1];
						held_tag[i] = held_tag[i-1];
					end
					held_seq[pos] = r.seq_number;
					held_tag[pos] = r.payload_tag;
					held_count++;
					e.status = ST_INSERTED;
				end
			end else begin
				n = 0;
				while (n < held_count && held_seq[n] < r.seq_number)
					n++;
				for (i = n; i < held_count; i++) begin
					held_seq[i-n] = held_seq[i];
					held_tag[i-n] = held_tag[i];
				end
				held_count -= n;
				e.status       = ST_PURGED;
				e.purged_count = n[CNT_W-1:0];
			end
			e.occupancy = held_count[CNT_W-1:0];
			awaited_rsp.push_back(e);
		endfunction

		task report_mismatch(input string msg);
			if (errors < 100)
				$display("[%0t] %s", $time, msg);
			errors++;
		endtask

		task check_result(input sro_rsp_t got);
			sro_rsp_t e;

			if (awaited_rsp.size() == 0) begin
				report_mismatch($sformatf("result with no request outstanding: %p", got));
			end else begin
				e = awaited_rsp.pop_front();
				if (got.status !== e.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						got.status, e.status));
				if (got.occupancy !== e.occupancy)
					report_mismatch($sformatf("occupancy got %0d expected %0d",
						got.occupancy, e.occupancy));
				if (got.purged_count !== e.purged_count)
					report_mismatch($sformatf("purged_count got %0d expected %0d",
						got.purged_count, e.purged_count));
			end
		endtask
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	sro_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	sro_rsp_t rsp;

	reorder_shadow    book;
	logic [SEQ_W-1:0] window_base;
	bit               long_hold_pending;
	int unsigned      cycle_count;

	sorted_reorder_buffer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			book.check_result(rsp);

	function automatic sro_req_t make_req(input sro_func_t f, input logic [SEQ_W-1:0] s,
			input logic [TAG_W-1:0] t);
		sro_req_t r;

		r.func        = f;
		r.seq_number  = s;
		r.payload_tag = t;
		return r;
	endfunction

	// Mostly packets inside a sliding window, purges advancing it, plus some noise.
	function automatic sro_req_t random_req();
		sro_req_t    r;
		int unsigned pick;

		pick          = $urandom_range(0, 99);
		r.payload_tag = TAG_W'($urandom_range(0, 16'hFFFF));
		if (pick < 2) begin
			window_base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFE0 : $urandom;
		end
		if (pick < 6) begin
			r.func       = ($urandom_range(0, 1) == 1) ? FUNC_PURGE : FUNC_INSERT;
			r.seq_number = $urandom;
		end else if (pick < 76) begin
			r.func       = FUNC_INSERT;
			r.seq_number = window_base + $urandom_range(0, 47);
		end else if (pick < 79) begin
			r.func       = FUNC_PURGE;
			r.seq_number = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : '0;
		end else begin
			r.func       = FUNC_PURGE;
			r.seq_number = window_base + $urandom_range(0, 24);
			if ($urandom_range(0, 1) == 1)
				window_base = r.seq_number;
		end
		return r;
	endfunction

	// Called and returning at a falling edge.
	task automatic send_request(input sro_req_t r, input int unsigned gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		book.note_request(r);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (book.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned hold;
		int unsigned taken;
		bit          calm;

		taken = 0;
		calm  = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken % 64 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (long_hold_pending) begin
				hold              = LONG_HOLD;
				long_hold_pending = 1'b0;
			end else begin
				hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		int unsigned k;
		int unsigned ph;
		int unsigned gap;
		bit          calm;

		arst_n            = 1'b0;
		req_valid         = 1'b0;
		req               = '0;
		rsp_stall         = 1'b0;
		long_hold_pending = 1'b0;
		window_base       = $urandom;
		book              = new();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(make_req(FUNC_PURGE, 32'hFFFF_FFFF, 16'h0000), 0);
		send_request(make_req(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF), 0);
		send_request(make_req(FUNC_INSERT, 32'h0000_0000, 16'h0000), 0);
		send_request(make_req(FUNC_INSERT, 32'h0000_0000, 16'h5A5A), 1);
		// fill in descending order so every insert shifts the held entries
		for (k = 0; k < 14; k++)
			send_request(make_req(FUNC_INSERT, 32'd1000 - 50 * k, 16'(k * 4681)), 0);
		send_request(make_req(FUNC_INSERT, 32'hFFFF_FFFF, 16'h1234), 0);
		send_request(make_req(FUNC_INSERT, 32'd5, 16'hA5A5), 0);
		send_request(make_req(FUNC_PURGE, 32'h0000_0000, 16'hFFFF), 2);
		send_request(make_req(FUNC_PURGE, 32'hFFFF_FFFF, 16'h0000), 0);
		send_request(make_req(FUNC_PURGE, 32'hFFFF_FFFF, 16'h0000), 0);
		send_request(make_req(FUNC_PURGE, 32'h0000_0001, 16'h0000), 0);
		drain_results();

		for (ph = 0; ph < PHASES; ph++) begin
			calm = (ph == 3) || ($urandom_range(0, 3) == 0);
			if (ph == 3)
				long_hold_pending = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
				send_request(random_req(), gap);
			end
			if (ph == 4 || ph == 7)
				drain_results();
		end

		drain_results();
		repeat (40) @(negedge clk);
		if (book.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
